// File: rtl/lmx_pkg.sv
// Shared types, codes and constants for the Lamport mutual exclusion node.
// Used by lmx_front, lmx_back and lamport_mutex_node; depends on nothing.
`default_nettype none

package lmx_pkg;

	localparam int MAX_NODES = 16;
	localparam int TIME_BITS = 15;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [TIME_BITS-1:0] CLOCK_MAX = {TIME_BITS{1'b1}};

	// operation field
	localparam logic [1:0] OP_LOCAL_REQ = 2'd0;
	localparam logic [1:0] OP_LOCAL_REL = 2'd1;
	localparam logic [1:0] OP_RECEIVED  = 2'd2;

	// msg_type field
	localparam logic [1:0] MSG_REQUEST = 2'd0;
	localparam logic [1:0] MSG_REPLY   = 2'd1;
	localparam logic [1:0] MSG_RELEASE = 2'd2;
	localparam logic [1:0] MSG_DONE    = 2'd3;

	// action field
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_REQUEST = 3'd1;
	localparam logic [2:0] ACT_REPLY   = 3'd2;
	localparam logic [2:0] ACT_RELEASE = 3'd3;
	localparam logic [2:0] ACT_ERROR   = 3'd4;

	// classified command kinds
	localparam logic [2:0] K_NONE    = 3'd0;
	localparam logic [2:0] K_ERROR   = 3'd1;
	localparam logic [2:0] K_LREQ    = 3'd2;
	localparam logic [2:0] K_LREL    = 3'd3;
	localparam logic [2:0] K_RX_REQ  = 3'd4;
	localparam logic [2:0] K_RX_REPL = 3'd5;
	localparam logic [2:0] K_RX_REL  = 3'd6;
	localparam logic [2:0] K_RX_DONE = 3'd7;

	localparam logic [0:0] CFG_OWN_ID        = 1'd0;
	localparam logic [0:0] CFG_PROCESS_COUNT = 1'd1;

	typedef struct packed {
		logic [3:0] own_id;
		logic [4:0] process_count;
	} cfg_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [3:0]           sender;
		logic [TIME_BITS-1:0] msg_time;
	} cmd_t;

	function automatic logic [TIME_BITS-1:0] clock_inc(input logic [TIME_BITS-1:0] c);
		return (c == CLOCK_MAX) ? c : c + 1'b1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lmx_front.sv
// Front end: checks and classifies each incoming request, then queues it.
// Depends on lmx_pkg.
`default_nettype none

module lmx_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lmx_pkg::cfg_t                 cfg,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic [1:0]                    msg_type,
	input  wire logic [3:0]                    sender,
	input  wire logic [lmx_pkg::TIME_BITS-1:0] msg_time,
	output logic                               cmd_valid,
	output lmx_pkg::cmd_t                      cmd,
	input  wire logic                          cmd_pop
);

	lmx_pkg::cmd_t                   fifo_q [lmx_pkg::QDEPTH];
	logic [lmx_pkg::QPTR_W-1:0]      wr_q;
	logic [lmx_pkg::QPTR_W-1:0]      rd_q;
	logic [lmx_pkg::QPTR_W:0]        count_q;
	lmx_pkg::cmd_t                   cls;
	logic                            own_ok;
	logic                            snd_ok;
	logic                            push;

	always_comb begin
		own_ok = 32'(cfg.own_id) < lmx_pkg::MAX_NODES;
		snd_ok = (sender != cfg.own_id) && ({1'b0, sender} < cfg.process_count) &&
			(32'(sender) < lmx_pkg::MAX_NODES);
		cls.sender   = sender;
		cls.msg_time = msg_time;
		case (operation)
			lmx_pkg::OP_LOCAL_REQ: cls.kind = own_ok ? lmx_pkg::K_LREQ : lmx_pkg::K_ERROR;
			lmx_pkg::OP_LOCAL_REL: cls.kind = own_ok ? lmx_pkg::K_LREL : lmx_pkg::K_ERROR;
			lmx_pkg::OP_RECEIVED: begin
				if (!snd_ok) begin
					cls.kind = lmx_pkg::K_ERROR;
				end else begin
					case (msg_type)
						lmx_pkg::MSG_REQUEST: cls.kind = lmx_pkg::K_RX_REQ;
						lmx_pkg::MSG_REPLY:   cls.kind = lmx_pkg::K_RX_REPL;
						lmx_pkg::MSG_RELEASE: cls.kind = lmx_pkg::K_RX_REL;
						default:              cls.kind = lmx_pkg::K_RX_DONE;
					endcase
				end
			end
			default: cls.kind = lmx_pkg::K_NONE;
		endcase
	end

	assign item_stall = (count_q == (lmx_pkg::QPTR_W+1)'(lmx_pkg::QDEPTH));
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (count_q != '0);
	assign cmd        = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/lmx_back.sv
// Back end: carries out queued commands on the clock, request table and
// tallies, scans the table for its head and registers one result per command.
// Depends on lmx_pkg.
`default_nettype none

module lmx_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lmx_pkg::cfg_t                 cfg,
	input  wire logic                          cmd_valid,
	input  wire lmx_pkg::cmd_t                 cmd,
	output logic                               cmd_pop,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [2:0]                         action,
	output logic [3:0]                         dest,
	output logic [lmx_pkg::TIME_BITS-1:0]      stamp,
	output logic                               granted,
	output logic [3:0]                         done_total
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_APPLY  = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam int TW = lmx_pkg::TIME_BITS;
	localparam int NW = lmx_pkg::NODE_W;

	logic [1:0]                 state_q;
	lmx_pkg::cmd_t              cmd_q;
	logic                       applied_q;
	logic [TW-1:0]              clock_q;
	logic                       valid_q [lmx_pkg::MAX_NODES];
	logic [TW-1:0]              time_q  [lmx_pkg::MAX_NODES];
	logic [4:0]                 reply_q;
	logic [3:0]                 done_q;
	logic                       waiting_q;
	logic [2:0]                 action_q;
	logic [3:0]                 dest_q;
	logic [TW-1:0]              stamp_q;
	logic [NW-1:0]              scan_q;
	logic                       best_valid_q;
	logic [NW-1:0]              best_idx_q;
	logic [TW-1:0]              best_time_q;
	logic                       result_valid_q;
	logic [2:0]                 res_action_q;
	logic [3:0]                 res_dest_q;
	logic [TW-1:0]              res_stamp_q;
	logic                       res_granted_q;
	logic [3:0]                 res_done_q;

	logic [TW-1:0]              inc1;
	logic [TW-1:0]              rx1;
	logic [TW-1:0]              rx2;
	logic [NW-1:0]              own_idx;
	logic [NW-1:0]              snd_idx;
	logic                       head_own;
	logic                       take;
	logic                       scan_last;
	logic [4:0]                 needed;
	logic                       grant_now;
	logic                       out_free;
	logic                       fin_load;

	always_comb begin
		inc1      = lmx_pkg::clock_inc(clock_q);
		rx1       = lmx_pkg::clock_inc((cmd_q.msg_time > clock_q) ? cmd_q.msg_time : clock_q);
		rx2       = lmx_pkg::clock_inc(rx1);
		own_idx   = NW'(cfg.own_id);
		snd_idx   = NW'(cmd_q.sender);
		head_own  = best_valid_q && (32'(best_idx_q) == 32'(cfg.own_id));
		take      = valid_q[scan_q] && (!best_valid_q || (time_q[scan_q] < best_time_q));
		scan_last = (scan_q == NW'(lmx_pkg::MAX_NODES - 1));
		needed    = (cfg.process_count >= 5'd2) ? cfg.process_count - 5'd2 : 5'd0;
		grant_now = waiting_q && (32'(cfg.own_id) < lmx_pkg::MAX_NODES) && head_own &&
			(reply_q == needed);
		out_free  = !result_valid_q || !result_stall;
		fin_load  = (state_q == ST_FINISH) && out_free;
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	// table timestamps hold no reset; valid bits guard them
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			if (cmd_q.kind == lmx_pkg::K_LREQ) begin
				time_q[own_idx] <= inc1;
			end else if (cmd_q.kind == lmx_pkg::K_RX_REQ) begin
				time_q[snd_idx] <= cmd_q.msg_time;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= '0;
			applied_q    <= 1'b0;
			clock_q      <= '0;
			for (int i = 0; i < lmx_pkg::MAX_NODES; i++) begin
				valid_q[i] <= 1'b0;
			end
			reply_q      <= '0;
			done_q       <= '0;
			waiting_q    <= 1'b0;
			action_q     <= lmx_pkg::ACT_NONE;
			dest_q       <= '0;
			stamp_q      <= '0;
			scan_q       <= '0;
			best_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q        <= cmd;
						applied_q    <= 1'b0;
						action_q     <= lmx_pkg::ACT_NONE;
						dest_q       <= '0;
						stamp_q      <= '0;
						scan_q       <= '0;
						best_valid_q <= 1'b0;
						// a release needs the head before it acts
						state_q <= (cmd.kind == lmx_pkg::K_LREL) ? ST_SCAN : ST_APPLY;
					end
				end
				ST_APPLY: begin
					applied_q    <= 1'b1;
					scan_q       <= '0;
					best_valid_q <= 1'b0;
					state_q      <= (cmd_q.kind == lmx_pkg::K_LREL) ? ST_FINISH : ST_SCAN;
					case (cmd_q.kind)
						lmx_pkg::K_ERROR: begin
							action_q <= lmx_pkg::ACT_ERROR;
						end
						lmx_pkg::K_LREQ: begin
							clock_q          <= inc1;
							valid_q[own_idx] <= 1'b1;
							reply_q          <= '0;
							waiting_q        <= 1'b1;
							action_q         <= lmx_pkg::ACT_REQUEST;
							stamp_q          <= inc1;
						end
						lmx_pkg::K_LREL: begin
							if (head_own) begin
								valid_q[own_idx] <= 1'b0;
								waiting_q        <= 1'b0;
								clock_q          <= inc1;
								action_q         <= lmx_pkg::ACT_RELEASE;
								stamp_q          <= inc1;
							end else begin
								action_q <= lmx_pkg::ACT_ERROR;
							end
						end
						lmx_pkg::K_RX_REQ: begin
							valid_q[snd_idx] <= 1'b1;
							clock_q          <= rx2;
							action_q         <= lmx_pkg::ACT_REPLY;
							dest_q           <= cmd_q.sender;
							stamp_q          <= rx2;
						end
						lmx_pkg::K_RX_REPL: begin
							clock_q <= rx1;
							if (reply_q != 5'd31) begin
								reply_q <= reply_q + 5'd1;
							end
						end
						lmx_pkg::K_RX_REL: begin
							clock_q          <= rx1;
							valid_q[snd_idx] <= 1'b0;
						end
						lmx_pkg::K_RX_DONE: begin
							clock_q <= rx1;
							if (done_q != 4'd15) begin
								done_q <= done_q + 4'd1;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					if (take) begin
						best_valid_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						state_q <= applied_q ? ST_FINISH : ST_APPLY;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// head candidate payload; best_valid_q qualifies it
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && take) begin
			best_idx_q  <= scan_q;
			best_time_q <= time_q[scan_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			res_action_q  <= action_q;
			res_dest_q    <= dest_q;
			res_stamp_q   <= stamp_q;
			res_granted_q <= grant_now;
			res_done_q    <= done_q;
		end
	end

	assign result_valid = result_valid_q;
	assign action       = res_action_q;
	assign dest         = res_dest_q;
	assign stamp        = res_stamp_q;
	assign granted      = res_granted_q;
	assign done_total   = res_done_q;

endmodule

`default_nettype wire

// File: rtl/lamport_mutex_node.sv
// Top level of one Lamport mutual exclusion node: configuration registers,
// front end (classify and queue) and back end (execute, scan, result).
// Depends on lmx_pkg, lmx_front and lmx_back.
//
//   channel   handshake               payload
//   item      item_valid/item_stall   operation, msg_type, sender, msg_time
//   result    result_valid/result_stall  action, dest, stamp, granted, done_total
//   config    cfg_we                  cfg_index, cfg_data
//
// In the back end each request is picked up, updates state, has the request table
// scanned for its head (one entry a cycle, every table entry; a local release scans
// before it updates) and has its result registered. A two-entry queue lets the front
// take requests while the back works. Reset clears the clock, tallies and table valid
// bits at once. A stalled result holds the back end; the front stalls on a full queue.
`default_nettype none

module lamport_mutex_node (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [4:0]                    cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    operation,
	input  wire logic [1:0]                    msg_type,
	input  wire logic [3:0]                    sender,
	input  wire logic [lmx_pkg::TIME_BITS-1:0] msg_time,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [2:0]                         action,
	output logic [3:0]                         dest,
	output logic [lmx_pkg::TIME_BITS-1:0]      stamp,
	output logic                               granted,
	output logic [3:0]                         done_total
);

	lmx_pkg::cfg_t cfg_q;
	logic          cmd_valid;
	lmx_pkg::cmd_t cmd;
	logic          cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id        <= 4'd1;
			cfg_q.process_count <= 5'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				lmx_pkg::CFG_OWN_ID:        cfg_q.own_id        <= cfg_data[3:0];
				lmx_pkg::CFG_PROCESS_COUNT: cfg_q.process_count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lmx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.msg_type   (msg_type),
		.sender     (sender),
		.msg_time   (msg_time),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	lmx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.action       (action),
		.dest         (dest),
		.stamp        (stamp),
		.granted      (granted),
		.done_total   (done_total)
	);

	// a release gives up the critical section
	a_release_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == lmx_pkg::ACT_RELEASE |-> !granted)
		else $error("grant reported with a release");

	// only a reply carries a destination
	a_dest_only_reply: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action != lmx_pkg::ACT_REPLY |-> dest == 4'd0)
		else $error("destination set on a non-reply result");

	// no message goes out with an error or with no action
	a_quiet_no_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (action == lmx_pkg::ACT_ERROR || action == lmx_pkg::ACT_NONE)
		|-> stamp == '0)
		else $error("stamp set on a result that sends nothing");

	// a reply stamp comes from a clock advanced on receipt and again for the reply
	a_reply_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == lmx_pkg::ACT_REPLY |-> stamp >= 2)
		else $error("reply stamp too small");

endmodule

`default_nettype wire

// File: verif/lamport_mutex_node_test.sv
// Self-checking testbench for lamport_mutex_node: drives requests through the
// valid/stall ports, predicts every result in-bench and compares field by field.
// Depends on lmx_pkg and the lamport_mutex_node RTL only.

module lamport_mutex_node_test;

	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 25;
	localparam int TB_W          = lmx_pkg::TIME_BITS;

	typedef struct packed {
		logic [1:0]      op;
		logic [1:0]      kind;
		logic [3:0]      src;
		logic [TB_W-1:0] ts;
	} req_t;

	typedef struct packed {
		logic [2:0]      act;
		logic [3:0]      dst;
		logic [TB_W-1:0] stamp;
		logic            grant;
		logic [3:0]      dones;
	} res_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [0:0]      cfg_index;
	logic [4:0]      cfg_data;
	logic            item_valid;
	logic            item_stall;
	logic [1:0]      operation;
	logic [1:0]      msg_type;
	logic [3:0]      sender;
	logic [TB_W-1:0] msg_time;
	logic            result_valid;
	logic            result_stall;
	logic [2:0]      action;
	logic [3:0]      dest;
	logic [TB_W-1:0] stamp;
	logic            granted;
	logic [3:0]      done_total;

	lamport_mutex_node u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .msg_type(msg_type), .sender(sender), .msg_time(msg_time),
		.result_valid(result_valid), .result_stall(result_stall),
		.action(action), .dest(dest), .stamp(stamp), .granted(granted),
		.done_total(done_total)
	);

	always #5 clk = ~clk;

	// node state mirror
	logic [TB_W-1:0] lclock;
	logic            tbl_valid [lmx_pkg::MAX_NODES];
	logic [TB_W-1:0] tbl_time [lmx_pkg::MAX_NODES];
	logic [4:0]      replies;
	logic [3:0]      dones;
	logic            waiting;
	logic [3:0]      m_own;
	logic [4:0]      m_pc;

	req_t req_queue[$];
	res_t predicted[$];
	res_t want;

	int  items_made;
	int  time_hint;
	int  fail_count;
	int  results_seen;
	int  cycle_count;
	int  send_gap;
	int  stall_left;
	int  hold_left;
	bit  item_went;
	bit  idle_on;
	bit  sender_hold;
	bit  long_hold_req;
	bit  wide_times;

	function automatic logic [TB_W-1:0] sat_inc(input logic [TB_W-1:0] c);
		return (c == {TB_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic int table_head();
		int best;
		best = -1;
		for (int i = 0; i < lmx_pkg::MAX_NODES; i++)
			if (tbl_valid[i] && (best < 0 || tbl_time[i] < tbl_time[best]))
				best = i;
		return best;
	endfunction

	function automatic res_t step_node(input req_t r);
		res_t o;
		logic [4:0] need;
		o = '0;
		case (r.op)
			lmx_pkg::OP_LOCAL_REQ: begin
				lclock = sat_inc(lclock);
				tbl_valid[m_own] = 1'b1;
				tbl_time[m_own] = lclock;
				replies = '0;
				waiting = 1'b1;
				o.act = lmx_pkg::ACT_REQUEST;
				o.stamp = lclock;
			end
			lmx_pkg::OP_LOCAL_REL: begin
				if (table_head() != int'(m_own)) begin
					o.act = lmx_pkg::ACT_ERROR;
				end else begin
					tbl_valid[m_own] = 1'b0;
					waiting = 1'b0;
					lclock = sat_inc(lclock);
					o.act = lmx_pkg::ACT_RELEASE;
					o.stamp = lclock;
				end
			end
			lmx_pkg::OP_RECEIVED: begin
				if (r.src == m_own || {1'b0, r.src} >= m_pc) begin
					o.act = lmx_pkg::ACT_ERROR;
				end else begin
					lclock = sat_inc((r.ts > lclock) ? r.ts : lclock);
					case (r.kind)
						lmx_pkg::MSG_REQUEST: begin
							tbl_valid[r.src] = 1'b1;
							tbl_time[r.src] = r.ts;
							lclock = sat_inc(lclock);
							o.act = lmx_pkg::ACT_REPLY;
							o.dst = r.src;
							o.stamp = lclock;
						end
						lmx_pkg::MSG_REPLY: if (replies != 5'd31) replies = replies + 1'b1;
						lmx_pkg::MSG_RELEASE: tbl_valid[r.src] = 1'b0;
						default: if (dones != 4'd15) dones = dones + 1'b1;
					endcase
				end
			end
			default: o.act = lmx_pkg::ACT_NONE;
		endcase
		need = (m_pc >= 5'd2) ? m_pc - 5'd2 : 5'd0;
		o.grant = waiting && table_head() == int'(m_own) && replies == need;
		o.dones = dones;
		return o;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		fail_count++;
		$display("mismatch on %s at result %0d: got %0d, expected %0d",
			what, results_seen, got, exp_val);
	endtask

	// stimulus helpers
	task automatic push_req(input logic [1:0] op, input logic [1:0] kind,
			input logic [3:0] src, input logic [TB_W-1:0] ts);
		req_t r;
		r.op = op;
		r.kind = kind;
		r.src = src;
		r.ts = ts;
		req_queue.push_back(r);
		if (op != OP_UNDEFINED)
			items_made++;
	endtask

	function automatic logic [3:0] pick_sender();
		int span;
		logic [3:0] s;
		span = (m_pc > lmx_pkg::MAX_NODES) ? lmx_pkg::MAX_NODES : int'(m_pc);
		s = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 19) == 0 || span == 0)
			return s;
		repeat (8) begin
			s = 4'($urandom_range(0, span - 1));
			if (s != m_own)
				return s;
		end
		return s;
	endfunction

	function automatic logic [TB_W-1:0] pick_time();
		int t;
		if (wide_times)
			return TB_W'($urandom_range(0, 32767));
		t = time_hint + int'($urandom_range(0, 24)) - 8;
		if ($urandom_range(0, 99) == 0)
			t = t + int'($urandom_range(0, 2000));
		time_hint = time_hint + 2;
		if (t < 0)
			t = 0;
		if (t > 32767)
			t = 32767;
		return TB_W'(t);
	endfunction

	task automatic add_episode();
		int n;
		int need;
		logic [3:0] rival;
		logic [1:0] kind;
		bit rival_in;
		bit own_in;
		need = (m_pc >= 5'd2) ? int'(m_pc) - 2 : 0;
		rival = pick_sender();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// own critical section: request, collect replies, release
				push_req(lmx_pkg::OP_LOCAL_REQ, 2'($urandom_range(0, 3)),
					4'($urandom_range(0, 15)), pick_time());
				rival_in = ($urandom_range(0, 2) == 0);
				if (rival_in)
					push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REQUEST, rival, pick_time());
				n = need + int'($urandom_range(0, 2)) - 1;
				repeat ((n < 0) ? 0 : n)
					push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REPLY, pick_sender(),
						pick_time());
				if ($urandom_range(0, 4) == 0)
					push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_DONE, pick_sender(),
						pick_time());
				push_req(lmx_pkg::OP_LOCAL_REL, 2'($urandom_range(0, 3)),
					4'($urandom_range(0, 15)), pick_time());
				if (rival_in)
					push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_RELEASE, rival, pick_time());
			end
			4, 5: begin
				// remote critical section, possibly with our own request queued behind
				push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REQUEST, rival, pick_time());
				own_in = 1'($urandom_range(0, 1));
				if (own_in)
					push_req(lmx_pkg::OP_LOCAL_REQ, 2'($urandom_range(0, 3)),
						4'($urandom_range(0, 15)), pick_time());
				push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_RELEASE, rival, pick_time());
				if (own_in)
					push_req(lmx_pkg::OP_LOCAL_REL, 2'($urandom_range(0, 3)),
						4'($urandom_range(0, 15)), pick_time());
			end
			6: begin
				kind = $urandom_range(0, 1) ? lmx_pkg::MSG_REPLY : lmx_pkg::MSG_DONE;
				repeat ($urandom_range(1, 36))
					push_req(lmx_pkg::OP_RECEIVED, kind, pick_sender(), pick_time());
			end
			default: begin
				repeat ($urandom_range(1, 4))
					push_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
						4'($urandom_range(0, 15)), pick_time());
			end
		endcase
	endtask

	task automatic run_items(input int count);
		int goal;
		goal = items_made + count;
		while (items_made < goal) begin
			time_hint = int'(lclock);
			repeat (4)
				add_episode();
			while (req_queue.size() > 2)
				@(negedge clk);
		end
		while (req_queue.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		while (req_queue.size() != 0 || predicted.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_config(input logic [4:0] own_val, input logic [4:0] count_val);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= lmx_pkg::CFG_OWN_ID;
		cfg_data <= own_val;
		@(negedge clk);
		cfg_index <= lmx_pkg::CFG_PROCESS_COUNT;
		cfg_data <= count_val;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_own = own_val[3:0];
		m_pc = count_val;
	endtask

	// own request followed by a rival request carrying the very same timestamp
	task automatic tie_probe();
		logic [3:0] rival;
		push_req(lmx_pkg::OP_LOCAL_REQ, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		while (req_queue.size() != 0)
			@(negedge clk);
		rival = pick_sender();
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REQUEST, rival, tbl_time[m_own]);
		push_req(lmx_pkg::OP_LOCAL_REL, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_RELEASE, rival, tbl_time[m_own]);
		push_req(lmx_pkg::OP_LOCAL_REL, lmx_pkg::MSG_REQUEST, 4'd0, '0);
	endtask

	// request driver: hold payload while stalled, advance on acceptance
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_went)) begin
			if (send_gap != 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (req_queue.size() != 0 && !sender_hold) begin
				item_valid <= 1'b1;
				operation <= req_queue[0].op;
				msg_type <= req_queue[0].kind;
				sender <= req_queue[0].src;
				msg_time <= req_queue[0].ts;
				if (idle_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 5);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		item_went = item_valid && !item_stall;
		if (item_went)
			predicted.push_back(step_node(req_queue.pop_front()));
	end

	// result stall: random bursts plus one long hold-off on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = 160;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (predicted.size() == 0) begin
				note_mismatch("result with nothing pending", 32'(action),
					32'(lmx_pkg::ACT_NONE));
			end else begin
				want = predicted.pop_front();
				if (action !== want.act)
					note_mismatch("action", 32'(action), 32'(want.act));
				if (dest !== want.dst)
					note_mismatch("dest", 32'(dest), 32'(want.dst));
				if (stamp !== want.stamp)
					note_mismatch("stamp", 32'(stamp), 32'(want.stamp));
				if (granted !== want.grant)
					note_mismatch("granted", 32'(granted), 32'(want.grant));
				if (done_total !== want.dones)
					note_mismatch("done_total", 32'(done_total), 32'(want.dones));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lmx_pkg::CFG_OWN_ID;
		cfg_data = '0;
		item_valid = 1'b0;
		operation = lmx_pkg::OP_LOCAL_REQ;
		msg_type = lmx_pkg::MSG_REQUEST;
		sender = '0;
		msg_time = '0;
		result_stall = 1'b0;
		items_made = 0;
		fail_count = 0;
		results_seen = 0;
		cycle_count = 0;
		send_gap = 0;
		stall_left = 0;
		hold_left = 0;
		item_went = 1'b0;
		idle_on = 1'b1;
		sender_hold = 1'b0;
		long_hold_req = 1'b0;
		wide_times = 1'b0;
		lclock = '0;
		for (int i = 0; i < lmx_pkg::MAX_NODES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_time[i] = '0;
		end
		replies = '0;
		dones = '0;
		waiting = 1'b0;
		m_own = 4'd1;
		m_pc = 5'd2;

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: only node 0 is a legal sender
		push_req(lmx_pkg::OP_LOCAL_REL, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		push_req(OP_UNDEFINED, lmx_pkg::MSG_DONE, 4'd15, '1);
		push_req(lmx_pkg::OP_LOCAL_REQ, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REPLY, 4'd0, 15'd3);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REQUEST, 4'd1, 15'd4);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_DONE, 4'd2, 15'd4);
		push_req(lmx_pkg::OP_LOCAL_REQ, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REQUEST, 4'd0, 15'd0);
		push_req(lmx_pkg::OP_LOCAL_REL, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_RELEASE, 4'd0, 15'd9);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_RELEASE, 4'd0, 15'd9);
		push_req(lmx_pkg::OP_LOCAL_REL, lmx_pkg::MSG_REQUEST, 4'd0, '0);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_DONE, 4'd0, 15'd2);

		set_config(5'd0, 5'd16);
		tie_probe();
		time_hint = int'(lclock);
		repeat (33)
			push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REPLY, 4'd7, pick_time());
		run_items(200);

		// upper data bit written to own_id is dropped
		set_config(5'h1f, 5'd16);
		tie_probe();
		run_items(120);
		sender_hold = 1'b1;
		@(negedge clk);
		while (item_valid || predicted.size() != 0)
			@(negedge clk);
		sender_hold = 1'b0;
		run_items(120);

		set_config(5'd7, 5'd5);
		long_hold_req = 1'b1;
		run_items(240);

		set_config(5'd2, 5'd1);
		run_items(180);

		set_config(5'd3, 5'd0);
		idle_on = 1'b0;
		run_items(60);
		idle_on = 1'b1;

		set_config(5'd9, 5'd31);
		run_items(220);

		set_config(5'd15, 5'd2);
		run_items(150);

		set_config(5'd4, 5'd12);
		idle_on = 1'b0;
		run_items(200);
		// drive the clock into saturation
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REPLY, 4'd5, '1);
		push_req(lmx_pkg::OP_LOCAL_REQ, lmx_pkg::MSG_DONE, 4'd15, '1);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_REQUEST, 4'd6, 15'd32766);
		push_req(lmx_pkg::OP_RECEIVED, lmx_pkg::MSG_RELEASE, 4'd6, '1);
		push_req(lmx_pkg::OP_LOCAL_REL, lmx_pkg::MSG_REPLY, 4'd9, '1);
		wide_times = 1'b1;
		run_items(100);

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/lmx_pkg.sv
rtl/lmx_front.sv
rtl/lmx_back.sv
rtl/lamport_mutex_node.sv
verif/lamport_mutex_node_test.sv
